// ===== rtl/polyline_stroke_tessellator_defines.svh =====
// Assertion macros used by the checker file.
`ifndef POLYLINE_STROKE_TESSELLATOR_DEFINES_SVH
`define POLYLINE_STROKE_TESSELLATOR_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define PST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/pst_pkg.sv =====
package pst_pkg;
    localparam int unsigned CoordW = 24;
    localparam int unsigned NormW  = 16;
    localparam int unsigned WidthW = 16;
    localparam logic [WidthW-1:0] WidthReset = 16'd256;
    localparam logic signed [NormW-1:0] Q14One = 16'sd16384;
    localparam logic signed [CoordW-1:0] CoordMax = 24'sh7FFFFF;
    localparam logic signed [CoordW-1:0] CoordMin = 24'sh800000;

    typedef struct packed {
        logic signed [CoordW-1:0] vertex_x;
        logic signed [CoordW-1:0] vertex_y;
        logic                     starts_line;
    } t_vin;

    typedef struct packed {
        logic signed [CoordW-1:0] out_x;
        logic signed [CoordW-1:0] out_y;
        logic                     last_of_run;
    } t_vout;

    // Saturate a wide sum to the signed coordinate range.
    function automatic logic signed [CoordW-1:0] sat24(input logic signed [27:0] v);
        logic signed [CoordW-1:0] r;
        if (v > 28'(CoordMax)) begin
            r = CoordMax;
        end else if (v < 28'(CoordMin)) begin
            r = CoordMin;
        end else begin
            r = v[CoordW-1:0];
        end
        return r;
    endfunction
endpackage

// ===== rtl/pst_stream_if.sv =====
interface pst_stream_if #(parameter int unsigned W = 49);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/pst_div.sv =====
// Restoring divider, one quotient bit per cycle: q = num / den.
module pst_div
    import pst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic [63:0] r_quo, n_quo;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [32:0] w_sh;

    always_comb begin
        w_sh  = {r_rem[31:0], r_quo[63]};
        n_quo = {r_quo[62:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem    = w_sh - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
    end

    // One shift-subtract step per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_quo;
endmodule

// ===== rtl/polyline_stroke_tessellator.sv =====
// Channel  | Direction | Payload
// in_v     | sink      | vertex_x, vertex_y, starts_line
// out_v    | source    | out_x, out_y, last_of_run
// cfg      | write     | stroke width (i_cfg_we, i_cfg_wdata)
// A vertex that starts a line is taken in S_IDLE; the input is ready again next cycle.
// A later vertex goes through the square root, each of the two divisions and the
// offsets before its first output vertex is valid (a zero-length edge skips the
// divisions). Then 6 or 12 output transfers follow at one per cycle while out_v is ready,
// and the input is ready again in the cycle after the last one.
// Output stalls hold the current output vertex. Reset is synchronous.
module polyline_stroke_tessellator
    import pst_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_wdata,
    pst_stream_if.sink     in_v,
    pst_stream_if.source   out_v
);
    typedef enum logic [3:0] {
        S_IDLE, S_SQRT, S_DIVX, S_WX, S_DIVY, S_WY, S_OFF, S_EMIT
    } t_state;

    t_state r_state;
    logic [WidthW-1:0] r_width;
    logic signed [CoordW-1:0] r_lx, r_ly, r_px, r_py;
    logic signed [NormW-1:0] r_pnx, r_pny, r_nx, r_ny;
    logic [1:0] r_seen;
    logic r_joint;
    logic signed [24:0] r_dx, r_dy;
    logic [63:0] r_rad, r_root, r_bit;
    logic [4:0] r_idx;
    logic [3:0] r_emit;
    logic signed [CoordW:0] r_ox, r_oy, r_qx, r_qy;
    t_vin w_in;
    t_vout r_out;

    logic        w_dstart, w_ddone;
    logic [63:0] w_dnum, w_quo;
    logic [31:0] w_dden;

    assign w_in = t_vin'(in_v.data);
    assign in_v.ready = (r_state == S_IDLE);
    assign out_v.data = r_out;

    pst_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_dnum), .i_den(w_dden), .o_done(w_ddone), .o_quo(w_quo)
    );

    // Magnitude of a component times 2^21 plus half the divisor.
    function automatic logic [63:0] num_of(input logic signed [24:0] c,
                                          input logic [63:0] s);
        logic [24:0] m;
        m = c[24] ? 25'(-c) : 25'(c);
        return ({39'd0, m} << 21) + (s >> 1);
    endfunction

    // Clamp a quotient to one and restore the sign.
    function automatic logic signed [NormW-1:0] to_norm(input logic [63:0] q,
                                                       input logic neg);
        logic [15:0] m;
        m = (q > 64'd16384) ? 16'd16384 : q[15:0];
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // Offset = round(|n| * width / 2^15) with the sign of n.
    function automatic logic signed [CoordW:0] off_of(input logic signed [NormW-1:0] n,
                                                     input logic [WidthW-1:0] w);
        logic [15:0] m;
        logic [31:0] p;
        logic [16:0] r;
        m = n[15] ? 16'(-n) : 16'(n);
        p = m * w;
        r = 17'((33'(p) + 33'd16384) >> 15);
        return n[15] ? -$signed(25'(r)) : $signed(25'(r));
    endfunction

    assign w_dstart = (r_state == S_DIVX || r_state == S_DIVY);
    assign w_dnum = (r_state == S_DIVX) ? num_of(-r_dy, r_root) : num_of(r_dx, r_root);
    assign w_dden = r_root[31:0];

    // Square-root step on the shared registers.
    logic [63:0] w_sum;
    assign w_sum = r_root + r_bit;

    // Output vertex selection for the emit sequence.
    logic signed [27:0] w_bx, w_by;
    logic signed [CoordW:0] w_fx, w_fy;
    logic w_useb;
    always_comb begin
        w_useb = 1'b0;
        w_fx = '0;
        w_fy = '0;
        case (r_emit)
            4'd0, 4'd3: begin w_fx = '0; w_fy = '0; end
            4'd1: begin w_fx = -r_qx; w_fy = -r_qy; end
            4'd2: begin w_fx = -r_ox; w_fy = -r_oy; end
            4'd4: begin w_fx = r_ox; w_fy = r_oy; end
            4'd5: begin w_fx = r_qx; w_fy = r_qy; end
            4'd6: begin w_fx = r_ox; w_fy = r_oy; end
            4'd7: begin w_fx = -r_ox; w_fy = -r_oy; end
            4'd8, 4'd9: begin w_fx = r_ox; w_fy = r_oy; w_useb = 1'b1; end
            4'd10: begin w_fx = -r_ox; w_fy = -r_oy; end
            default: begin w_fx = -r_ox; w_fy = -r_oy; w_useb = 1'b1; end
        endcase
        w_bx = 28'(w_useb ? r_px : r_lx) + 28'(w_fx);
        w_by = 28'(w_useb ? r_py : r_ly) + 28'(w_fy);
    end

    // Sequencer with the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_width <= WidthReset;
            r_lx <= '0; r_ly <= '0;
            r_pnx <= '0; r_pny <= '0;
            r_seen <= 2'd0;
            r_rad <= '0; r_root <= '0; r_bit <= '0;
            out_v.valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_width <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_v.valid) begin
                        r_px <= w_in.vertex_x;
                        r_py <= w_in.vertex_y;
                        if (w_in.starts_line || r_seen == 2'd0) begin
                            r_lx <= w_in.vertex_x;
                            r_ly <= w_in.vertex_y;
                            r_seen <= 2'd1;
                        end else begin
                            r_dx <= 25'(w_in.vertex_x) - 25'(r_lx);
                            r_dy <= 25'(w_in.vertex_y) - 25'(r_ly);
                            r_joint <= (r_seen == 2'd2);
                            r_idx <= 5'd0;
                            r_state <= S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    // First cycle loads L2 * 2^14; then 32 digit steps.
                    if (r_idx == 5'd0 && r_bit == 64'd0 && r_root == 64'd0 && r_rad == 64'd0) begin
                        r_rad <= (64'($signed(r_dx) * $signed(r_dx))
                                + 64'($signed(r_dy) * $signed(r_dy))) << 14;
                        r_bit <= 64'd1 << 62;
                        r_idx <= 5'd1;
                    end else begin
                        if (r_rad >= w_sum) begin
                            r_rad  <= r_rad - w_sum;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                        r_idx <= r_idx + 5'd1;
                        if (r_idx == 5'd0) begin
                            if (r_dx == 0 && r_dy == 0) begin
                                r_nx <= Q14One;
                                r_ny <= '0;
                                r_state <= S_OFF;
                            end else begin
                                r_state <= S_DIVX;
                            end
                        end
                    end
                end
                S_DIVX: r_state <= S_WX;
                S_WX: begin
                    if (w_ddone) begin
                        r_nx <= to_norm(w_quo, r_dy > 0);
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: r_state <= S_WY;
                S_WY: begin
                    if (w_ddone) begin
                        r_ny <= to_norm(w_quo, r_dx < 0);
                        r_state <= S_OFF;
                    end
                end
                S_OFF: begin
                    r_ox <= off_of(r_nx, r_width);
                    r_oy <= off_of(r_ny, r_width);
                    r_qx <= off_of(r_pnx, r_width);
                    r_qy <= off_of(r_pny, r_width);
                    r_emit <= r_joint ? 4'd0 : 4'd6;
                    r_rad <= '0; r_root <= '0; r_bit <= '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!out_v.valid || out_v.ready) begin
                        if (out_v.valid && r_out.last_of_run) begin
                            out_v.valid <= 1'b0;
                            r_lx <= r_px; r_ly <= r_py;
                            r_pnx <= r_nx; r_pny <= r_ny;
                            r_seen <= 2'd2;
                            r_state <= S_IDLE;
                        end else begin
                            out_v.valid <= 1'b1;
                            r_out.out_x <= sat24(w_bx);
                            r_out.out_y <= sat24(w_by);
                            r_out.last_of_run <= (r_emit == 4'd11);
                            r_emit <= r_emit + 4'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/pst_checker.sv =====
`include "polyline_stroke_tessellator_defines.svh"
// Port-level checks on the tessellator.
module pst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_last
);
    // No new vertex is taken while output vertices are pending.
    `PST_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, out_valid, !in_ready)
    // A held output stays valid.
    `PST_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
    // After the last transfer the block drops valid.
    `PST_ASSERT_NEXT(a_end, i_clk, i_rst_n, out_valid && out_ready && out_last, !out_valid)
endmodule

bind polyline_stroke_tessellator pst_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_v.valid), .in_ready(in_v.ready),
    .out_valid(out_v.valid), .out_ready(out_v.ready),
    .out_last(out_v.data[0])
);
